// ----- src/bdec_pkg.sv -----
// ----------------------------------------------------------------------------
// bdec_pkg: shared types and helpers for the base64 stream decoder
// Character classification and the group entry passed from front to back.
// ----------------------------------------------------------------------------
`default_nettype none

package bdec_pkg;

    localparam logic [7:0] CHR_UPPER_A = 8'h41;
    localparam logic [7:0] CHR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHR_LOWER_A = 8'h61;
    localparam logic [7:0] CHR_LOWER_Z = 8'h7A;
    localparam logic [7:0] CHR_DIGIT_0 = 8'h30;
    localparam logic [7:0] CHR_DIGIT_9 = 8'h39;
    localparam logic [7:0] CHR_PLUS    = 8'h2B;
    localparam logic [7:0] CHR_SLASH   = 8'h2F;

    localparam logic [5:0] VAL_LOWER_BASE = 6'd26;
    localparam logic [5:0] VAL_DIGIT_BASE = 6'd52;
    localparam logic [5:0] VAL_PLUS       = 6'd62;
    localparam logic [5:0] VAL_SLASH      = 6'd63;

    // Decoded character: ok is low for '=' and anything outside the alphabet
    typedef struct packed {
        logic       ok;
        logic [5:0] val;
    } sextet_t;

    // One queue entry: up to three bytes, oldest in the top byte.
    // nbytes == 0 only for an end marker (last is then set).
    typedef struct packed {
        logic [23:0] bytes;
        logic [1:0]  nbytes;
        logic        last;
    } grp_t;

    // Head of the queue as seen by the back end
    typedef struct packed {
        logic valid;
        grp_t grp;
    } qhead_t;

    function automatic sextet_t decode_char(input logic [7:0] c);
        sextet_t r;
        logic [7:0] d;
        r = '0;
        d = '0;
        if (c >= CHR_UPPER_A && c <= CHR_UPPER_Z) begin
            d = c - CHR_UPPER_A;
            r = '{ok: 1'b1, val: d[5:0]};
        end else if (c >= CHR_LOWER_A && c <= CHR_LOWER_Z) begin
            d = c - CHR_LOWER_A;
            r = '{ok: 1'b1, val: d[5:0] + VAL_LOWER_BASE};
        end else if (c >= CHR_DIGIT_0 && c <= CHR_DIGIT_9) begin
            d = c - CHR_DIGIT_0;
            r = '{ok: 1'b1, val: d[5:0] + VAL_DIGIT_BASE};
        end else if (c == CHR_PLUS) begin
            r = '{ok: 1'b1, val: VAL_PLUS};
        end else if (c == CHR_SLASH) begin
            r = '{ok: 1'b1, val: VAL_SLASH};
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- src/base64_stream_decoder_unit.sv -----
// ----------------------------------------------------------------------------
// base64_stream_decoder_unit: streaming base64 decoder, top level
// Front end gathers sextets, a group queue decouples it from the byte output.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (s_*): one character per beat, s_end_of_string on the
//   final character of a string. Output channel (m_*): one decoded byte per
//   beat; m_has_data low marks an end-only beat, m_last_of_message flags the
//   final beat of each string.
//   Path: the group that a character completes is written into the group
//   queue; its bytes pass from the queue head into the output register.
//   Throughput: one character per cycle in, one byte per cycle out. A full
//   group of four characters makes three bytes, so the back end keeps up on
//   plain text; the QDEPTH-entry group queue absorbs bursts of end markers
//   and short strings, and s_ready drops only when the queue is full.
//   Receiver stall: the output register holds its beat while m_ready is low;
//   the queue fills, then s_ready goes low until space frees up.
//   Reset: aresetn (synchronous, active low) empties the queue, clears the
//   sextet buffer and the stop flag; the block is ready the next cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module base64_stream_decoder_unit #(
    parameter int QDEPTH = 4
) (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [7:0] s_char_code,
    input  wire logic       s_end_of_string,
    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_data_byte,
    output logic            m_has_data,
    output logic            m_last_of_message
);

    logic              q_full;
    logic              q_push;
    logic              q_pop;
    bdec_pkg::grp_t    q_grp;
    bdec_pkg::qhead_t  q_head;

    bdec_front u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_char_code     (s_char_code),
        .s_end_of_string (s_end_of_string),
        .q_full          (q_full),
        .q_push          (q_push),
        .q_grp           (q_grp)
    );

    bdec_fifo #(
        .QDEPTH (QDEPTH)
    ) u_fifo (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (q_push),
        .push_grp (q_grp),
        .full     (q_full),
        .pop      (q_pop),
        .head     (q_head)
    );

    bdec_back u_back (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .head              (q_head),
        .pop               (q_pop),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_data_byte       (m_data_byte),
        .m_has_data        (m_has_data),
        .m_last_of_message (m_last_of_message)
    );

endmodule

`default_nettype wire

// ----- src/bdec_front.sv -----
// ----------------------------------------------------------------------------
// bdec_front: character intake and sextet gathering
// Classifies each beat, packs sextets and pushes byte groups to the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module bdec_front (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           s_valid,
    output logic                s_ready,
    input  wire logic [7:0]     s_char_code,
    input  wire logic           s_end_of_string,
    input  wire logic           q_full,
    output logic                q_push,
    output bdec_pkg::grp_t      q_grp
);

    logic [17:0] buf_reg, buf_next;
    logic [1:0]  cnt_reg, cnt_next;
    logic        stopped_reg, stopped_next;

    bdec_pkg::sextet_t sx;
    logic        accept;
    logic        stop_now;
    logic        full_grp;
    logic        take;
    logic        flush;
    logic [17:0] buf_m;
    logic [1:0]  cnt_m;
    logic [23:0] word;

    assign s_ready = !q_full;
    assign accept  = s_valid && s_ready;
    assign sx      = bdec_pkg::decode_char(s_char_code);
    assign word    = {buf_reg, sx.val};

    always_comb begin
        stop_now = !stopped_reg && !sx.ok;
        take     = !stopped_reg && sx.ok;
        full_grp = take && (cnt_reg == 2'd3);
        // flush on a stop, or at end of string while still decoding
        flush    = stop_now || (s_end_of_string && take);

        if (full_grp) begin
            buf_m = '0;
            cnt_m = '0;
        end else if (take) begin
            buf_m = {buf_reg[11:0], sx.val};
            cnt_m = cnt_reg + 2'd1;
        end else begin
            buf_m = buf_reg;
            cnt_m = cnt_reg;
        end

        q_grp = '0;
        if (full_grp) begin
            q_grp.bytes  = word;
            q_grp.nbytes = 2'd3;
        end else if (flush) begin
            unique case (cnt_m)
                2'd2: begin
                    q_grp.bytes  = {buf_m[11:4], 16'h0000};
                    q_grp.nbytes = 2'd1;
                end
                2'd3: begin
                    q_grp.bytes  = {buf_m[17:10], buf_m[9:2], 8'h00};
                    q_grp.nbytes = 2'd2;
                end
                default: begin
                    q_grp.bytes  = '0;
                    q_grp.nbytes = 2'd0;
                end
            endcase
        end
        q_grp.last = s_end_of_string;
        q_push     = accept && ((q_grp.nbytes != 2'd0) || s_end_of_string);

        if (s_end_of_string) begin
            buf_next     = '0;
            cnt_next     = '0;
            stopped_next = 1'b0;
        end else begin
            buf_next     = flush ? 18'd0 : buf_m;
            cnt_next     = flush ? 2'd0 : cnt_m;
            stopped_next = stopped_reg || stop_now;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            buf_reg     <= '0;
            cnt_reg     <= '0;
            stopped_reg <= 1'b0;
        end else if (accept) begin
            buf_reg     <= buf_next;
            cnt_reg     <= cnt_next;
            stopped_reg <= stopped_next;
        end
    end

endmodule

`default_nettype wire

// ----- src/bdec_fifo.sv -----
// ----------------------------------------------------------------------------
// bdec_fifo: group queue between front and back
// Small register queue of byte groups; head is visible without a pop.
// ----------------------------------------------------------------------------
`default_nettype none

module bdec_fifo #(
    parameter int QDEPTH = 4
) (
    input  wire logic           aclk,
    input  wire logic           aresetn,
    input  wire logic           push,
    input  wire bdec_pkg::grp_t push_grp,
    output logic                full,
    input  wire logic           pop,
    output bdec_pkg::qhead_t    head
);

    localparam int PW = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CW = $clog2(QDEPTH + 1);
    localparam logic [PW-1:0] LAST_PTR = PW'(QDEPTH - 1);
    localparam logic [CW-1:0] DEPTH_C  = CW'(QDEPTH);

    bdec_pkg::grp_t mem_reg [QDEPTH];
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]  count_reg, count_next;
    logic           do_push, do_pop;

    assign full       = (count_reg == DEPTH_C);
    assign head       = '{valid: (count_reg != '0), grp: mem_reg[rd_ptr_reg]};
    assign do_push    = push && !full;
    assign do_pop     = pop && head.valid;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PW'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PW'(1);
        end
        count_next = count_reg + CW'(do_push) - CW'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem_reg[wr_ptr_reg] <= push_grp;
        end
    end

endmodule

`default_nettype wire

// ----- src/bdec_back.sv -----
// ----------------------------------------------------------------------------
// bdec_back: byte serializer and output register
// Walks the head group one byte per beat and drives the result channel.
// ----------------------------------------------------------------------------
`default_nettype none

module bdec_back (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire bdec_pkg::qhead_t head,
    output logic                  pop,
    output logic                  m_valid,
    input  wire logic             m_ready,
    output logic [7:0]            m_data_byte,
    output logic                  m_has_data,
    output logic                  m_last_of_message
);

    logic [1:0] idx_reg, idx_next;
    logic       valid_reg, valid_next;
    logic [7:0] data_reg, data_next;
    logic       has_reg, has_next;
    logic       last_reg, last_next;

    logic       load;
    logic [1:0] last_idx;
    logic       at_end;

    assign load     = !valid_reg || m_ready;
    assign last_idx = (head.grp.nbytes == 2'd0) ? 2'd0 : head.grp.nbytes - 2'd1;
    assign at_end   = (idx_reg == last_idx);
    assign pop      = load && head.valid && at_end;

    always_comb begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        data_next  = data_reg;
        has_next   = has_reg;
        last_next  = last_reg;
        if (load) begin
            valid_next = head.valid;
            if (head.valid) begin
                unique case (idx_reg)
                    2'd0:    data_next = head.grp.bytes[23:16];
                    2'd1:    data_next = head.grp.bytes[15:8];
                    default: data_next = head.grp.bytes[7:0];
                endcase
                has_next  = (head.grp.nbytes != 2'd0);
                last_next = head.grp.last && at_end;
                idx_next  = at_end ? 2'd0 : idx_reg + 2'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            idx_reg   <= '0;
            valid_reg <= 1'b0;
        end else begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        data_reg <= data_next;
        has_reg  <= has_next;
        last_reg <= last_next;
    end

    assign m_valid           = valid_reg;
    assign m_data_byte       = data_reg;
    assign m_has_data        = has_reg;
    assign m_last_of_message = last_reg;

endmodule

`default_nettype wire

// ----- src/bdec_checker.sv -----
// ----------------------------------------------------------------------------
// bdec_checker: port-level checks for the base64 stream decoder
// Watches the result channel over time; bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module bdec_checker (
    input wire logic       aclk,
    input wire logic       aresetn,
    input wire logic       m_valid,
    input wire logic       m_ready,
    input wire logic [7:0] m_data_byte,
    input wire logic       m_has_data,
    input wire logic       m_last_of_message
);

    // no result beat right after reset
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

    // an end-only beat always closes the message
    a_marker_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_data |-> m_last_of_message)
        else $error("end marker without last flag");

    // end-only beat carries a zero byte
    a_marker_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_has_data |-> m_data_byte == 8'h00)
        else $error("end marker with nonzero byte");

    a_hold_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid)
        else $error("result valid dropped while stalled");

endmodule

bind base64_stream_decoder_unit bdec_checker u_bdec_checker (
    .aclk              (aclk),
    .aresetn           (aresetn),
    .m_valid           (m_valid),
    .m_ready           (m_ready),
    .m_data_byte       (m_data_byte),
    .m_has_data        (m_has_data),
    .m_last_of_message (m_last_of_message)
);

`default_nettype wire
